/* rtl/eap_pkg.sv */
// Package for the encoder address picker: request codes, field widths,
// fixed constants and the registered request type.
// No dependencies.
`default_nettype none

package eap_pkg;

    localparam int ADDR_W  = 7;   // address field and stored entries
    localparam int COUNT_W = 8;   // use counters
    localparam int POS_W   = 3;   // stored_position field
    localparam int SLOTF_W = 2;   // pick_index and recent_slot fields
    localparam int DELTA_W = 8;

    localparam int COUNT_MAX  = 255;
    localparam int RESET_ADDR = 50;
    localparam int MID_STEP   = 2;
    localparam int BIG_STEP   = 3;

    localparam logic [1:0] REQ_STEP   = 2'd0;
    localparam logic [1:0] REQ_PICK   = 2'd1;
    localparam logic [1:0] REQ_COMMIT = 2'd2;

    typedef struct packed {
        logic [1:0]                req_type;
        logic signed [DELTA_W-1:0] delta;
        logic [SLOTF_W-1:0]        pick_index;
    } eap_req_t;

endpackage

`default_nettype wire

/* rtl/encoder_address_picker_lfu.sv */
// Encoder address picker with a least-used set of remembered addresses.
// Depends on eap_pkg.
//
//  port group | dir | bits carried
//  -----------+-----+-----------------------------------------------------------
//  s_*        | in  | tuser: req_type; tdata: delta, pick_index
//  m_*        | out | tdata: current_address, stored_position, changed, recent_slot
//
// One beat per cycle sustained while m_tready stays high.
// Input register, then one pass of cursor/slot logic into the result register.
// The state update is taken as the beat moves into the result register.
// Stall on m_ holds both stages; s_tready falls only when both are full.
// aresetn is synchronous; state returns to the first stored slot.
`default_nettype none

module encoder_address_picker_lfu #(
    parameter int SLOTS         = 4,
    parameter int MAX_REAL_ADDR = 99
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] delta, [9:8] pick_index, rest zero
    input  wire logic [1:0]  s_tuser,   // [1:0] req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // [6:0] current_address, [9:7] stored_position,
                                        // [10] changed, [12:11] recent_slot, rest zero
);

    localparam int TOP    = MAX_REAL_ADDR + SLOTS;
    localparam int CUR_W  = $clog2(TOP + 1);
    localparam int SW     = CUR_W + 2;
    localparam int SLOT_W = $clog2(SLOTS);

    // ---- state ----
    logic [CUR_W-1:0]                    cursor_reg, cursor_next;
    logic [eap_pkg::ADDR_W-1:0]          picked_reg, picked_next;
    logic [eap_pkg::ADDR_W-1:0]          stored_reg [SLOTS];
    logic [eap_pkg::ADDR_W-1:0]          stored_next [SLOTS];
    logic [eap_pkg::COUNT_W-1:0]         count_reg [SLOTS];
    logic [eap_pkg::COUNT_W-1:0]         count_next [SLOTS];
    logic [SLOT_W-1:0]                   last_reg, last_next;

    // ---- stages ----
    logic              in_valid_reg;
    eap_pkg::eap_req_t in_reg;
    logic              out_valid_reg;
    logic [15:0]       out_data_reg, out_data_next;
    logic              out_load;

    assign out_load = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_reg.req_type   <= s_tuser;
            in_reg.delta      <= s_tdata[7:0];
            in_reg.pick_index <= s_tdata[9:8];
        end
        if (out_load)
            out_data_reg <= out_data_next;
    end

    // ---- one pass of request logic ----
    logic signed [SW-1:0]         c;
    logic                         up, gt1, gt3;
    logic [SLOT_W+1:0]            pick_wide;
    logic [SLOT_W-1:0]            pick_slot;
    logic [CUR_W-1:0]             pidx_cur, pidx_nxt;
    logic [eap_pkg::ADDR_W-1:0]   addr_cur, addr_nxt;
    logic                         found, changed;
    logic [SLOT_W-1:0]            match_idx, low_idx;
    logic [eap_pkg::COUNT_W-1:0]  low;
    logic [eap_pkg::POS_W-1:0]    pos;
    logic [CUR_W-1:0]             pos_wide;
    logic [SLOT_W+1:0]            last_wide;

    always_comb begin
        cursor_next = cursor_reg;
        picked_next = picked_reg;
        last_next   = last_reg;
        stored_next = stored_reg;
        count_next  = count_reg;
        changed     = 1'b0;
        found       = 1'b0;
        match_idx   = '0;
        low         = eap_pkg::COUNT_W'(eap_pkg::COUNT_MAX);
        low_idx     = '0;

        up  = in_reg.delta > 0;
        gt1 = up ? (in_reg.delta > 1) : (in_reg.delta < -1);
        gt3 = up ? (in_reg.delta > 3) : (in_reg.delta < -3);

        pick_wide = (SLOT_W + 2)'(in_reg.pick_index);
        pick_slot = pick_wide[SLOT_W-1:0];

        // address under the present cursor
        pidx_cur = cursor_reg - CUR_W'(MAX_REAL_ADDR + 1);
        addr_cur = (int'(cursor_reg) <= MAX_REAL_ADDR) ?
                   eap_pkg::ADDR_W'(cursor_reg) : stored_reg[pidx_cur[SLOT_W-1:0]];

        // lowest-numbered slot holding the address
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (stored_reg[i] == addr_cur) begin
                found     = 1'b1;
                match_idx = SLOT_W'(i);
            end
        end
        // least used, highest-numbered on a tie
        for (int i = 0; i < SLOTS; i++) begin
            if (count_reg[i] <= low) begin
                low     = count_reg[i];
                low_idx = SLOT_W'(i);
            end
        end

        c = SW'(signed'({2'b00, cursor_reg}));

        case (in_reg.req_type)
            eap_pkg::REQ_STEP: begin
                if (up) begin
                    c = c + SW'(1);
                    if (c < MAX_REAL_ADDR - 2) begin
                        if (gt1) c = c + SW'(eap_pkg::MID_STEP);
                        if (gt3) c = c + SW'(eap_pkg::BIG_STEP);
                    end
                    if (c < 1 || c > TOP)
                        c = SW'(1);
                end else begin
                    c = c - SW'(1);
                    if (c <= MAX_REAL_ADDR) begin
                        if (gt1) c = c - SW'(eap_pkg::MID_STEP);
                        if (gt3) c = c - SW'(eap_pkg::BIG_STEP);
                    end
                    if (c < 1 || c > TOP)
                        c = SW'(TOP);
                end
                cursor_next = c[CUR_W-1:0];
            end
            eap_pkg::REQ_PICK: begin
                if (int'(in_reg.pick_index) < SLOTS) begin
                    cursor_next = CUR_W'(MAX_REAL_ADDR + 1) + CUR_W'(in_reg.pick_index);
                    picked_next = stored_reg[pick_slot];
                end
            end
            eap_pkg::REQ_COMMIT: begin
                if (addr_cur != picked_reg) begin
                    changed = 1'b1;
                    if (found) begin
                        last_next = match_idx;
                        if (int'(count_reg[match_idx]) < eap_pkg::COUNT_MAX)
                            count_next[match_idx] = count_reg[match_idx] +
                                                    eap_pkg::COUNT_W'(1);
                    end else begin
                        last_next              = low_idx;
                        stored_next[low_idx]   = addr_cur;
                        count_next[low_idx]    = eap_pkg::COUNT_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase

        // report from the updated state
        pidx_nxt = cursor_next - CUR_W'(MAX_REAL_ADDR + 1);
        if (int'(cursor_next) <= MAX_REAL_ADDR) begin
            addr_nxt = eap_pkg::ADDR_W'(cursor_next);
            pos_wide = '0;
        end else begin
            addr_nxt = stored_next[pidx_nxt[SLOT_W-1:0]];
            pos_wide = cursor_next - CUR_W'(MAX_REAL_ADDR);
        end
        pos       = pos_wide[eap_pkg::POS_W-1:0];
        last_wide = (SLOT_W + 2)'(last_next);

        out_data_next = {3'b000, last_wide[1:0], changed, pos, addr_nxt};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg <= CUR_W'(MAX_REAL_ADDR + 1);
            picked_reg <= eap_pkg::ADDR_W'(eap_pkg::RESET_ADDR);
            last_reg   <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                stored_reg[i] <= eap_pkg::ADDR_W'(eap_pkg::RESET_ADDR + i);
                count_reg[i]  <= '0;
            end
        end else if (out_load) begin
            cursor_reg <= cursor_next;
            picked_reg <= picked_next;
            last_reg   <= last_next;
            stored_reg <= stored_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(cursor_reg) >= 1 && int'(cursor_reg) <= TOP)
        else $error("cursor outside real and pseudo range");

    a_pos_matches_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[9:7] == 3'd0) == (int'(cursor_reg) <= MAX_REAL_ADDR)))
        else $error("stored_position disagrees with cursor");

    a_recent_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[12:11] == 2'(last_reg)))
        else $error("recent_slot disagrees with last slot");

    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && m_tvalid && !m_tready))
        else $error("input stalled with room in the pipe");
`endif

endmodule

`default_nettype wire

/* sim/tb_encoder_address_picker_lfu.sv */
// Self-checking bench for encoder_address_picker_lfu: a queue-fed driver issues steps, picks,
// commits and spare codes with random gaps, and a transaction-level predictor checks every beat.
// Depends on eap_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_encoder_address_picker_lfu;

    localparam int SLOTS       = 4;
    localparam int MAX_ADDR    = 99;
    localparam int N_ITEMS     = 1150;
    localparam int CYCLE_LIMIT = 600000;
    localparam int REPORT_MAX  = 10;
    localparam logic [1:0] REQ_SPARE = 2'd3;   // unused code, block only reports

    typedef struct {
        logic [1:0] req;
        logic [7:0] delta;
        logic [1:0] idx;
        bit         drain;      // hold this beat back until all results are in
    } pend_t;

    typedef struct {
        logic [eap_pkg::ADDR_W-1:0]  addr;
        logic [eap_pkg::POS_W-1:0]   pos;
        logic                        chg;
        logic [eap_pkg::SLOTF_W-1:0] slot;
    } pick_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    pend_t     pend_q[$];
    pend_t     cur_item;
    pick_res_t addr_expect_q[$];

    // predictor state
    int              cursor;
    logic [7:0]      picked_addr;
    logic [7:0]      slot_addr[SLOTS];
    logic [7:0]      slot_uses[SLOTS];
    logic [1:0]      recent;

    int  cycles = 0;
    bit  calm = 1'b0;
    int  send_gap = 0;
    int  stall_left = 0;
    int  n_sent = 0, n_total = 0, n_checked = 0, n_errors = 0;
    int  n_steps = 0, n_picks = 0, n_commits = 0, n_changed = 0;
    int  n_wraps = 0, n_replaced = 0, n_saturated = 0;

    encoder_address_picker_lfu #(
        .SLOTS         (SLOTS),
        .MAX_REAL_ADDR (MAX_ADDR)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 aclk = ~aclk;

    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [7:0] rand_delta();
        if ($urandom_range(0, 1) == 0) return 8'($signed($urandom_range(0, 8)) - 4);
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] cursor_addr();
        if (cursor <= MAX_ADDR) return 8'(cursor);
        return slot_addr[(cursor - MAX_ADDR - 1) % SLOTS];
    endfunction

    task automatic reset_picker();
        cursor      = MAX_ADDR + 1;
        picked_addr = 8'(eap_pkg::RESET_ADDR);
        for (int i = 0; i < SLOTS; i++) begin
            slot_addr[i] = 8'(eap_pkg::RESET_ADDR + i);
            slot_uses[i] = '0;
        end
        recent = '0;
    endtask

    task automatic move_cursor(input logic [7:0] dl);
        int d, mag;
        d   = int'($signed(dl));
        mag = d > 0 ? d : -d;
        if (d > 0) begin
            cursor++;
            // coarse steps only well clear of the pseudo range
            if (cursor < MAX_ADDR - 2) begin
                if (mag > 1) cursor += eap_pkg::MID_STEP;
                if (mag > 3) cursor += eap_pkg::BIG_STEP;
            end
            if (cursor < 1 || cursor > MAX_ADDR + SLOTS) begin
                cursor = 1;
                n_wraps++;
            end
        end else begin
            cursor--;
            if (cursor <= MAX_ADDR) begin
                if (mag > 1) cursor -= eap_pkg::MID_STEP;
                if (mag > 3) cursor -= eap_pkg::BIG_STEP;
            end
            if (cursor < 1 || cursor > MAX_ADDR + SLOTS) begin
                cursor = MAX_ADDR + SLOTS;
                n_wraps++;
            end
        end
    endtask

    function automatic logic commit_cursor();
        logic [7:0] addr;
        int low;
        addr = cursor_addr();
        if (addr == picked_addr) return 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_addr[i] == addr) begin
                recent = 2'(i);
                if (slot_uses[i] < eap_pkg::COUNT_MAX) slot_uses[i]++;
                else n_saturated++;
                return 1'b1;
            end
        end
        // least used slot, highest index wins a tie
        low = eap_pkg::COUNT_MAX;
        for (int i = 0; i < SLOTS; i++)
            if (slot_uses[i] < low) low = slot_uses[i];
        for (int i = 0; i < SLOTS; i++)
            if (slot_uses[i] == low) recent = 2'(i);
        slot_addr[recent] = addr;
        slot_uses[recent] = 8'd1;
        n_replaced++;
        return 1'b1;
    endfunction

    task automatic track_picker(input logic [1:0] req, input logic [7:0] dl,
                                input logic [1:0] idx);
        pick_res_t r;
        r.chg = 1'b0;
        case (req)
            eap_pkg::REQ_STEP: begin
                move_cursor(dl);
                n_steps++;
            end
            eap_pkg::REQ_PICK: begin
                if (idx < SLOTS) begin
                    cursor      = MAX_ADDR + 1 + idx;
                    picked_addr = slot_addr[idx];
                end
                n_picks++;
            end
            eap_pkg::REQ_COMMIT: begin
                r.chg = commit_cursor();
                n_commits++;
                if (r.chg) n_changed++;
            end
            default: ;
        endcase
        r.addr = cursor_addr();
        r.pos  = cursor <= MAX_ADDR ? '0 : eap_pkg::POS_W'(cursor - MAX_ADDR);
        r.slot = recent;
        addr_expect_q.push_back(r);
    endtask

    task automatic add_req(input logic [1:0] req, input logic [7:0] dl,
                           input logic [1:0] idx, input bit drain = 1'b0);
        pend_t p;
        p.req   = req;
        p.delta = dl;
        p.idx   = idx;
        p.drain = drain;
        pend_q.push_back(p);
    endtask

    task automatic compare_beat(input logic [15:0] data);
        pick_res_t e;
        if (addr_expect_q.size() == 0) begin
            n_errors++;
            if (n_errors <= REPORT_MAX)
                $display("%0t: result beat with nothing expected, data %h", $realtime, data);
            return;
        end
        e = addr_expect_q.pop_front();
        n_checked++;
        if (data[6:0] !== e.addr || data[9:7] !== e.pos || data[10] !== e.chg ||
            data[12:11] !== e.slot || data[15:13] !== 3'b000) begin
            n_errors++;
            if (n_errors <= REPORT_MAX)
                $display({"%0t: beat %0d mismatch: exp addr %0d pos %0d chg %0b slot %0d,",
                          " got addr %0d pos %0d chg %0b slot %0d pad %b"},
                         $realtime, n_checked, e.addr, e.pos, e.chg, e.slot,
                         data[6:0], data[9:7], data[10], data[12:11], data[15:13]);
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            send_gap <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                track_picker(s_tuser, s_tdata[7:0], s_tdata[9:8]);
                n_sent++;
            end
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pend_q.size() == 0 ||
                         (pend_q[0].drain && addr_expect_q.size() != 0)) begin
                s_tvalid <= 1'b0;
            end else begin
                cur_item = pend_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {6'b0, cur_item.idx, cur_item.delta};
                s_tuser  <= cur_item.req;
                send_gap <= calm ? 0 : pause_len();
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_tvalid && m_tready) compare_beat(m_tdata);
            if (calm) begin
                m_tready <= 1'b1;
            end else if (stall_left > 0) begin
                m_tready   <= 1'b0;
                stall_left <= stall_left - 1;
            end else if ($urandom_range(0, 3) == 0) begin
                m_tready   <= 1'b0;
                stall_left <= pause_len();
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog, and stretches with no idling on either side
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles % 256 == 0) calm <= ($urandom_range(0, 3) == 0);
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d of %0d beats sent",
                     cycles, n_sent, n_total);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int n_rand, nsteps;
        reset_picker();

        // directed: step sizes, both wraps, -128, commits that match, replace, bump
        add_req(eap_pkg::REQ_STEP,   8'h00, 2'd0);   // zero steps down
        add_req(eap_pkg::REQ_STEP,   8'h80, 2'd3);   // most negative
        add_req(eap_pkg::REQ_STEP,   8'h7F, 2'd0);   // big step up, lands on the last real address
        add_req(eap_pkg::REQ_STEP,   8'h04, 2'd1);   // only 1 near the pseudo range
        add_req(eap_pkg::REQ_STEP,   8'h01, 2'd2);
        add_req(eap_pkg::REQ_STEP,   8'h02, 2'd0);
        add_req(eap_pkg::REQ_STEP,   8'h03, 2'd0);
        add_req(eap_pkg::REQ_STEP,   8'h01, 2'd0);   // wrap up to 1
        add_req(eap_pkg::REQ_STEP,   8'hFF, 2'd0);   // wrap down to last pseudo
        add_req(eap_pkg::REQ_STEP,   8'h81, 2'd0);   // large down inside pseudo range: 1 only
        add_req(eap_pkg::REQ_PICK,   8'hAA, 2'd0);
        add_req(eap_pkg::REQ_COMMIT, 8'h55, 2'd1);   // same as picked: unchanged
        add_req(eap_pkg::REQ_STEP,   8'hFE, 2'd0);
        add_req(eap_pkg::REQ_COMMIT, 8'h00, 2'd0);   // new address replaces highest slot on tie
        add_req(eap_pkg::REQ_STEP,   8'h03, 2'd0);
        add_req(eap_pkg::REQ_COMMIT, 8'hFF, 2'd3);   // replaces next least used
        add_req(eap_pkg::REQ_PICK,   8'h00, 2'd2);
        add_req(eap_pkg::REQ_STEP,   8'hFF, 2'd0);
        add_req(eap_pkg::REQ_COMMIT, 8'h00, 2'd0);   // matches a stored slot: bump
        add_req(REQ_SPARE,           8'h55, 2'd3);
        add_req(eap_pkg::REQ_PICK,   8'h7F, 2'd3);
        add_req(eap_pkg::REQ_PICK,   8'h80, 2'd1);
        add_req(eap_pkg::REQ_STEP,   8'hFC, 2'd2);
        add_req(eap_pkg::REQ_STEP,   8'h02, 2'd1);
        add_req(REQ_SPARE,           8'hAA, 2'd0);

        n_rand = 0;
        while (n_rand < N_ITEMS) begin
            if (n_rand > N_ITEMS / 3 && n_saturated == 0 && pend_q.size() > 0 &&
                n_rand < N_ITEMS / 3 + 30) begin
                // one long run of commits on the same address drives a count to its ceiling
                add_req(eap_pkg::REQ_PICK, rand_delta(), 2'($urandom_range(0, 3)), 1'b1);
                add_req(eap_pkg::REQ_STEP, 8'hFF, 2'($urandom_range(0, 3)));
                for (int i = 0; i < 270; i++)
                    add_req(eap_pkg::REQ_COMMIT, rand_delta(), 2'($urandom_range(0, 3)));
                n_rand += 272;
                n_saturated = 1;   // marks the run as queued; cleared below
            end else if ($urandom_range(0, 9) < 7) begin
                add_req(eap_pkg::REQ_PICK, rand_delta(), 2'($urandom_range(0, 3)),
                        $urandom_range(0, 199) == 0);
                nsteps = $urandom_range(0, 6);
                for (int i = 0; i < nsteps; i++)
                    add_req(eap_pkg::REQ_STEP, rand_delta(), 2'($urandom_range(0, 3)));
                add_req(eap_pkg::REQ_COMMIT, rand_delta(), 2'($urandom_range(0, 3)));
                n_rand += nsteps + 2;
            end else begin
                add_req(2'($urandom_range(0, 3)), rand_delta(), 2'($urandom_range(0, 3)));
                n_rand++;
            end
        end
        n_saturated = 0;
        n_total = pend_q.size();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (n_sent < n_total || addr_expect_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("%0d beats sent, %0d results checked: %0d steps (%0d wraps), %0d picks",
                 n_sent, n_checked, n_steps, n_wraps, n_picks);
        $display("%0d commits, %0d changed, %0d slot replacements, %0d bumps at ceiling",
                 n_commits, n_changed, n_replaced, n_saturated);
        if (n_errors == 0 && addr_expect_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d errors", n_errors);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
